FILE: rtl/qfa_pkg.sv
// ----------------------------------------------------------------------------
// qfa_pkg
// Shared types and constants for the Q16.16 fixed-point unit.
// ----------------------------------------------------------------------------
package qfa_pkg;

	localparam int FracBits = 16;
	localparam int DivBits  = 48;

	typedef enum logic [2:0] {
		OP_FROM_INT = 3'd0,
		OP_TO_INT   = 3'd1,
		OP_MUL      = 3'd2,
		OP_DIV      = 3'd3,
		OP_CLAMP    = 3'd4
	} op_t;

	// classified item passed from front to back
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} item_t;

endpackage

FILE: rtl/qfa_front.sv
// ----------------------------------------------------------------------------
// qfa_front
// Two-entry queue ahead of the execution back end.
// ----------------------------------------------------------------------------
module qfa_front import qfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  item_t       in_item,
	output logic        q_valid,
	input  logic        q_stall,
	output item_t       q_item
);

	item_t       mem_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign in_stall = (cnt_q == 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_valid && !q_stall;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_item;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/qfa_back.sv
// ----------------------------------------------------------------------------
// qfa_back
// Execution pipeline: operand stage with multiply, 48-step divide, output.
// ----------------------------------------------------------------------------
module qfa_back import qfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_stall,
	input  item_t       q_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_result,
	output logic        out_dz
);

	localparam int NStg = DivBits + 2;

	// per-stage state: one divide step per stage between entry and output stages
	logic              v_q   [NStg];
	logic [2:0]        op_q  [NStg];
	logic [31:0]       res_q [NStg];
	logic              dz_q  [NStg];
	logic              neg_q [NStg];
	logic [DivBits-1:0] num_q [NStg];
	logic [31:0]       den_q [NStg];
	logic [32:0]       rem_q [NStg];

	logic adv;
	assign adv     = !(v_q[NStg-1] && out_stall);
	assign q_stall = !adv;

	logic [31:0]  a_mag, b_mag;
	logic [63:0]  prod_s;
	logic [31:0]  pre_res;

	assign a_mag = q_item.a[31] ? (~q_item.a + 32'd1) : q_item.a;
	assign b_mag = q_item.b[31] ? (~q_item.b + 32'd1) : q_item.b;
	assign prod_s = 64'($signed(q_item.a) * $signed(q_item.b));

	// non-divide results in the entry stage
	always_comb begin
		case (q_item.op)
			OP_FROM_INT: pre_res = {q_item.a[15:0], 16'd0};
			OP_TO_INT:   pre_res = {{16{q_item.a[31]}}, q_item.a[31:16]};
			OP_MUL:      pre_res = prod_s[47:16];
			OP_CLAMP: begin
				if ($signed(q_item.a) < $signed(q_item.b))      pre_res = q_item.b;
				else if ($signed(q_item.a) > $signed(q_item.c)) pre_res = q_item.c;
				else                                           pre_res = q_item.a;
			end
			default:     pre_res = 32'd0;
		endcase
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NStg; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= q_valid;
			for (int i = 1; i < NStg; i++) v_q[i] <= v_q[i-1];
		end
	end

	// datapath: restoring divide, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			op_q[0]  <= q_item.op;
			res_q[0] <= pre_res;
			dz_q[0]  <= (q_item.op == OP_DIV) && (q_item.b == 32'd0);
			neg_q[0] <= q_item.a[31] ^ q_item.b[31];
			num_q[0] <= {a_mag, 16'd0};
			den_q[0] <= b_mag;
			rem_q[0] <= 33'd0;
			for (int i = 1; i < NStg - 1; i++) begin
				op_q[i]  <= op_q[i-1];
				res_q[i] <= res_q[i-1];
				dz_q[i]  <= dz_q[i-1];
				neg_q[i] <= neg_q[i-1];
				den_q[i] <= den_q[i-1];
				if ({rem_q[i-1][31:0], num_q[i-1][DivBits-1]} >= {1'b0, den_q[i-1]}) begin
					rem_q[i] <= {rem_q[i-1][31:0], num_q[i-1][DivBits-1]}
						- {1'b0, den_q[i-1]};
					num_q[i] <= {num_q[i-1][DivBits-2:0], 1'b1};
				end else begin
					rem_q[i] <= {rem_q[i-1][31:0], num_q[i-1][DivBits-1]};
					num_q[i] <= {num_q[i-1][DivBits-2:0], 1'b0};
				end
			end
			// output stage
			dz_q[NStg-1]  <= dz_q[NStg-2];
			op_q[NStg-1]  <= op_q[NStg-2];
			neg_q[NStg-1] <= neg_q[NStg-2];
			num_q[NStg-1] <= num_q[NStg-2];
			den_q[NStg-1] <= den_q[NStg-2];
			rem_q[NStg-1] <= rem_q[NStg-2];
			if (op_q[NStg-2] == OP_DIV) begin
				if (dz_q[NStg-2])       res_q[NStg-1] <= 32'd0;
				else if (neg_q[NStg-2]) res_q[NStg-1] <= ~num_q[NStg-2][31:0] + 32'd1;
				else                    res_q[NStg-1] <= num_q[NStg-2][31:0];
			end else begin
				res_q[NStg-1] <= res_q[NStg-2];
			end
		end
	end

	assign out_valid  = v_q[NStg-1];
	assign out_result = res_q[NStg-1];
	assign out_dz     = dz_q[NStg-1];

endmodule

FILE: rtl/q16_16_fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// q16_16_fixed_point_alu_top
// Signed Q16.16 unit: from/to integer, multiply, divide, clamp.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid/in_stall  | op, first/second/third_operand
// out     | out_valid/out_stall| result, divide_by_zero
//
// One item per cycle while no output stall holds the back end; an accepted
// item passes through the two-entry queue, then through the 50-stage back end,
// whose depth is set by the 48-step restoring divide, one quotient bit per stage.
// Reset clears all valid state; payload registers are not reset.
// An output stall with a valid output freezes the whole back end; the queue
// keeps taking items until it holds two, then stalls the input.
module q16_16_fixed_point_alu_top import qfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic signed [31:0] first_operand,
	input  logic signed [31:0] second_operand,
	input  logic signed [31:0] third_operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] result,
	output logic        divide_by_zero
);

	item_t in_item, q_item;
	logic  q_valid, q_stall;
	logic [31:0] res_w;

	assign in_item = '{op: op, a: first_operand, b: second_operand, c: third_operand};

	qfa_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.q_valid, .q_stall, .q_item
	);

	qfa_back u_back (
		.clk, .arst_n, .q_valid, .q_stall, .q_item,
		.out_valid, .out_stall, .out_result(res_w), .out_dz(divide_by_zero)
	);

	assign result = $signed(res_w);

endmodule

FILE: rtl/qfa_checker.sv
// ----------------------------------------------------------------------------
// qfa_checker
// Port-level checks for the Q16.16 unit.
// ----------------------------------------------------------------------------
module qfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result,
	input logic        divide_by_zero
);

	// a flagged result is always zero
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result == 32'd0)
		else $error("divide by zero with nonzero result");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(divide_by_zero))
		else $error("stalled result changed");

	// no output right after reset
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid after reset");

endmodule

bind q16_16_fixed_point_alu_top qfa_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .result, .divide_by_zero
);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q16.16 fixed-point unit. Directed corner items
// and random items are pushed through the valid/stall input channel, each
// item's value and flag are predicted in place, and every output item is
// compared in order against the queue of predictions.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qfa_pkg::*;

	localparam int Latency   = 50;
	localparam int WatchLim  = 20000;
	localparam int MaxReport = 10;

	typedef struct {
		logic [31:0] value;
		logic        dz;
	} fx_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        op = '0;
	logic signed [31:0] first_operand = '0;
	logic signed [31:0] second_operand = '0;
	logic signed [31:0] third_operand = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [31:0] result;
	logic              divide_by_zero;

	fx_result_t pending_q[$];
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	bit timed_out = 1'b0;

	q16_16_fixed_point_alu_top DUT (.*);

	always #10 clk = ~clk;

	// compute the expected result of one item
	function automatic fx_result_t fx_compute(logic [2:0] code, logic [31:0] a,
		logic [31:0] b, logic [31:0] c);
		fx_result_t r;
		logic signed [63:0] prod;
		logic signed [63:0] num;
		logic signed [63:0] quo;
		r.value = '0;
		r.dz = 1'b0;
		case (code)
			OP_FROM_INT: r.value = {a[15:0], 16'h0000};
			OP_TO_INT: r.value = {{16{a[31]}}, a[31:16]};
			OP_MUL: begin
				prod = $signed(a) * $signed(b);
				r.value = prod[47:16];
			end
			OP_DIV: begin
				if (b == '0) begin
					r.dz = 1'b1;
				end else begin
					num = 64'($signed(a)) <<< 16;
					quo = num / 64'($signed(b));
					r.value = quo[31:0];
				end
			end
			OP_CLAMP: begin
				if ($signed(a) < $signed(b)) r.value = b;
				else if ($signed(a) > $signed(c)) r.value = c;
				else r.value = a;
			end
			default: r.value = '0;
		endcase
		return r;
	endfunction

	// send one item, with random sender gaps
	task automatic send_item(logic [2:0] code, logic [31:0] a, logic [31:0] b,
		logic [31:0] c);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		first_operand <= a;
		second_operand <= b;
		third_operand <= c;
		pending_q.push_back(fx_compute(code, a, b, c));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drain();
		go_idle();
		while (pending_q.size() != 0 && !timed_out) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000 | ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
			1: return 32'($signed($urandom_range(16)) - 8);
			2: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
			3: return 32'($urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000);
			default: return $urandom;
		endcase
	endfunction

	// corners of every operation, including unused codes
	task automatic test_directed();
		send_item(OP_FROM_INT, 32'h7FFF_FFFF, '0, '0);
		send_item(OP_FROM_INT, 32'h8000_0000, '0, '0);
		send_item(OP_FROM_INT, 32'hFFFF_FFFF, '0, '0);
		send_item(OP_TO_INT, 32'hFFFF_FFFF, '0, '0);
		send_item(OP_TO_INT, 32'h7FFF_FFFF, '0, '0);
		send_item(OP_TO_INT, 32'h8000_0000, '0, '0);
		send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, '0);
		send_item(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		send_item(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, '0);
		send_item(OP_MUL, 32'h0001_8000, 32'hFFFE_0000, 32'hFFFF_FFFF);
		// zero divisor
		send_item(OP_DIV, 32'h1234_5678, 32'h0, '0);
		send_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, '0);
		send_item(OP_DIV, 32'h8000_0000, 32'h0000_0001, '0);
		send_item(OP_DIV, 32'hFFFF_FFFF, 32'h0002_0000, '0);
		send_item(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		// clamp: below, above, inside, inverted bounds
		send_item(OP_CLAMP, 32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000);
		send_item(OP_CLAMP, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000);
		send_item(OP_CLAMP, 32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000);
		send_item(OP_CLAMP, 32'h0000_0005, 32'h0000_0010, 32'h0000_0001);
		send_item(OP_CLAMP, 32'h0000_0020, 32'h0000_0010, 32'h0000_0001);
		// unused codes
		send_item(3'd5, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(3'd7, 32'h1, 32'h0, 32'h0);
	endtask

	// random items in one idling phase
	task automatic test_random(int count, int gap, int stall);
		logic [2:0] code;
		send_gap_pct = gap;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			code = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4));
			send_item(code, rand_word(), ($urandom_range(15) == 0) ? 32'h0 : rand_word(),
				rand_word());
		end
	endtask

	// hold off sending until the unit is empty, then resume
	task automatic test_drain_pause();
		wait_drain();
		test_random(20, 0, 0);
	endtask

	// receiver stall driven at each edge
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// output checking
	always @(posedge clk) begin
		fx_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReport)
					$display("unexpected item: result=%h dz=%b", result, divide_by_zero);
			end else begin
				exp_r = pending_q.pop_front();
				if (result !== exp_r.value || divide_by_zero !== exp_r.dz) begin
					mismatches++;
					if (mismatches <= MaxReport)
						$display("mismatch: expected %h/%b actual %h/%b",
							exp_r.value, exp_r.dz, result, divide_by_zero);
				end
			end
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLim && !timed_out) begin
			timed_out = 1'b1;
			$display("watchdog expired");
			$display("q16_16_fixed_point_alu_top verification failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(175, 0, 0);
		test_random(175, 53, 0);
		test_drain_pause();
		test_random(175, 0, 53);
		test_random(155, 19, 19);
		wait_drain();
		stall_pct = 0;
		repeat (Latency + 10) @(posedge clk);
		$display("covered %0d items over four idling phases, %0d results checked",
			items_sent, results_seen);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("q16_16_fixed_point_alu_top verification clean");
		else
			$display("q16_16_fixed_point_alu_top verification failed");
		$finish;
	end

endmodule
